// ----- hdl/vertex_normal_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define VNA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VNA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define VNA_ASSERT(label, clk, rst, prop, msg)
`define VNA_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ----- hdl/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Widths, request and status codes, and the structs shared between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vna_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int IDX_W        = 10;
   localparam int CNT_W        = 11;
   localparam int POS_W        = 16;
   localparam int NRM_W        = 16;
   localparam int DIF_W        = POS_W + 1;
   localparam int PRD_W        = 2 * DIF_W;
   localparam int FACE_W       = PRD_W + 1;
   localparam int SUM_W        = FACE_W + 1;
   localparam int MAG_W        = SUM_W;
   localparam int MAG_NB       = 30;           // normalized magnitude bits
   localparam int SQ_W         = 2 * MAG_NB;
   localparam int LEN_W        = SQ_W + 2;
   localparam int V_W          = LEN_W + 1;
   localparam int ROOT_W       = 32;
   localparam int DIV_SHIFT    = 15;
   localparam int REM_W        = 48;
   localparam int Q_W          = 16;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_DEGEN = 2'd2;

   typedef enum logic [1:0] {
      REQ_WRITE_POS = 2'd0,
      REQ_CLEAR     = 2'd1,
      REQ_TRIANGLE  = 2'd2,
      REQ_READ      = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type     kind;
      logic             bad;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] c;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [POS_W-1:0] pz;
   } cmd_type;

   typedef struct packed {
      logic [NRM_W-1:0] nx;
      logic [NRM_W-1:0] ny;
      logic [NRM_W-1:0] nz;
      logic [1:0]       status;
   } res_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sx;
      logic [SUM_W-1:0] sy;
      logic [SUM_W-1:0] sz;
   } nrm_req_type;

   typedef struct packed {
      logic             done;
      logic             degen;
      logic [NRM_W-1:0] nx;
      logic [NRM_W-1:0] ny;
      logic [NRM_W-1:0] nz;
   } nrm_rsp_type;

endpackage
`default_nettype wire

// ----- hdl/vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// A triangle request makes three corner updates on one normalize unit, each a
//   shift search, an integer root and a division; a zero corner sum ends its
//   update after the shift search.
// Throughput: one request at a time in the back end; two queued in front.
// Reset: synchronous; a sweep then clears every normal store entry, full high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_normal_accumulator_macros.svh"
module vertex_normal_accumulator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration: vertex count
   input  wire logic                        csr_we,
   input  wire logic [vna_pkg::CNT_W-1:0]   csr_wdata,
   // request queue side
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [1:0]                  req_type,
   input  wire logic [vna_pkg::IDX_W-1:0]   req_vertex_a,
   input  wire logic [vna_pkg::IDX_W-1:0]   req_vertex_b,
   input  wire logic [vna_pkg::IDX_W-1:0]   req_vertex_c,
   input  wire logic [vna_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic [vna_pkg::POS_W-1:0]   req_pos_y,
   input  wire logic [vna_pkg::POS_W-1:0]   req_pos_z,
   // response queue side
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [vna_pkg::NRM_W-1:0]        rsp_normal_x,
   output logic [vna_pkg::NRM_W-1:0]        rsp_normal_y,
   output logic [vna_pkg::NRM_W-1:0]        rsp_normal_z,
   output logic [1:0]                       rsp_status
);
   import vna_pkg::*;

   // Front end range checks and queues requests; the back end runs one at a
   // time. The front queue lets requests pile up while a triangle is in
   // flight, and the response queue lets the back end finish its transfer
   // while the consumer is stalled.
   logic       front_full;
   logic       push_ok;
   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_pop;
   logic       res_valid;
   res_type    res;
   logic       res_ready;
   logic       init_busy;
   logic       res_push;
   logic       pop_ok;

   // two-entry response queue
   res_type    rq_ff [2];
   logic       rq_wr_ff, rq_wr_in;
   logic       rq_rd_ff, rq_rd_in;
   logic [1:0] rsp_cnt_ff, rsp_cnt_in;
   res_type    head;

   // no requests taken while the post-reset sweep runs
   assign req_full = front_full | init_busy;
   assign push_ok  = req_push & ~req_full;

   vna_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .push         (push_ok),
      .req_type     (req_type),
      .req_vertex_a (req_vertex_a),
      .req_vertex_b (req_vertex_b),
      .req_vertex_c (req_vertex_c),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .full         (front_full),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   vna_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .init_busy (init_busy)
   );

   assign res_ready = (rsp_cnt_ff != 2'd2);
   assign res_push  = res_valid & res_ready;
   assign rsp_empty = (rsp_cnt_ff == 2'd0);
   assign pop_ok    = rsp_pop & ~rsp_empty;
   assign head      = rq_ff[rq_rd_ff];

   assign rsp_normal_x = head.nx;
   assign rsp_normal_y = head.ny;
   assign rsp_normal_z = head.nz;
   assign rsp_status   = head.status;

   always_comb begin
      rq_wr_in = rq_wr_ff ^ res_push;
      rq_rd_in = rq_rd_ff ^ pop_ok;
      case ({res_push, pop_ok})
         2'b10:   rsp_cnt_in = rsp_cnt_ff + 2'd1;
         2'b01:   rsp_cnt_in = rsp_cnt_ff - 2'd1;
         default: rsp_cnt_in = rsp_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res;
      end
      if (reset) begin
         rq_wr_ff   <= 1'b0;
         rq_rd_ff   <= 1'b0;
         rsp_cnt_ff <= 2'd0;
      end else begin
         rq_wr_ff   <= rq_wr_in;
         rq_rd_ff   <= rq_rd_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   // the sweep must hold off all request transfers
   `VNA_ASSERT(a_init_holds_full, clock, reset, init_busy |-> req_full, "request taken during sweep")
   // response queue never overfills
   `VNA_ASSERT(a_rsp_depth, clock, reset, rsp_cnt_ff != 2'd3, "response queue overflow")
   // a result handed over by the back end is visible next cycle
   `VNA_ASSERT_NEXT(a_res_lands, clock, reset, res_push, !rsp_empty, "lost response")

endmodule
`default_nettype wire

// ----- hdl/vna_front.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator front end
// Holds the vertex count, range checks requests and queues them (two deep).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vna_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [vna_pkg::CNT_W-1:0]   csr_wdata,
   input  wire logic                        push,
   input  wire logic [1:0]                  req_type,
   input  wire logic [vna_pkg::IDX_W-1:0]   req_vertex_a,
   input  wire logic [vna_pkg::IDX_W-1:0]   req_vertex_b,
   input  wire logic [vna_pkg::IDX_W-1:0]   req_vertex_c,
   input  wire logic [vna_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic [vna_pkg::POS_W-1:0]   req_pos_y,
   input  wire logic [vna_pkg::POS_W-1:0]   req_pos_z,
   output logic                             full,
   output logic                             cmd_valid,
   output vna_pkg::cmd_type                 cmd,
   input  wire logic                        cmd_pop
);
   import vna_pkg::*;

   logic [CNT_W-1:0] vcount_ff, vcount_in;
   cmd_type          q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   cmd_type          cmd_new;

   function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                   input logic [CNT_W-1:0] lim);
      return ({1'b0, idx} < lim) && ({1'b0, idx} < CNT_W'(MAX_VERTICES));
   endfunction

   always_comb begin
      cmd_new.kind = req_kind_type'(req_type);
      cmd_new.a    = req_vertex_a;
      cmd_new.b    = req_vertex_b;
      cmd_new.c    = req_vertex_c;
      cmd_new.px   = req_pos_x;
      cmd_new.py   = req_pos_y;
      cmd_new.pz   = req_pos_z;
      case (cmd_new.kind)
         REQ_CLEAR: begin
            cmd_new.bad = 1'b0;
         end
         REQ_TRIANGLE: begin
            cmd_new.bad = !(idx_ok(req_vertex_a, vcount_ff) &&
                            idx_ok(req_vertex_b, vcount_ff) &&
                            idx_ok(req_vertex_c, vcount_ff));
         end
         default: begin
            cmd_new.bad = !idx_ok(req_vertex_a, vcount_ff);
         end
      endcase
   end

   always_comb begin
      vcount_in = csr_we ? csr_wdata : vcount_ff;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      case ({push, cmd_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
      if (reset) begin
         vcount_ff <= CNT_W'(MAX_VERTICES);
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         vcount_ff <= vcount_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/vna_norm.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator normalize unit
// Scales a sum vector, takes the integer root and divides out each component.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vna_norm (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vna_pkg::nrm_req_type  req,
   output vna_pkg::nrm_rsp_type       rsp
);
   import vna_pkg::*;

   typedef enum logic [5:0] {
      N_IDLE  = 6'b000001,
      N_SHIFT = 6'b000010,
      N_SQ    = 6'b000100,
      N_SQRT  = 6'b001000,
      N_LOAD  = 6'b010000,
      N_DIV   = 6'b100000
   } nrm_state_type;

   nrm_state_type     state_ff, state_in;
   logic              neg_ff [3], neg_in [3];
   logic [MAG_W-1:0]  mag_ff [3], mag_in [3];
   logic [4:0]        cnt_ff, cnt_in;
   logic [1:0]        comp_ff, comp_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [V_W-1:0]    v_ff, v_in;
   logic [V_W-1:0]    r_ff, r_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [NRM_W-1:0]  out_ff [3], out_in [3];
   logic              degen_ff, degen_in;
   logic              done_ff, done_in;

   logic [MAG_W-1:0]  m01, mx, mag_sel;
   logic [1:0]        sel_idx;
   logic [V_W-1:0]    bitv, tsum;
   logic [REM_W-1:0]  dk, num;
   logic [Q_W-1:0]    qf;

   always_comb begin
      m01     = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      mx      = (m01 > mag_ff[2]) ? m01 : mag_ff[2];
      sel_idx = (state_ff == N_SQ) ? cnt_ff[1:0] : comp_ff;
      case (sel_idx)
         2'd1:    mag_sel = mag_ff[1];
         2'd2:    mag_sel = mag_ff[2];
         default: mag_sel = mag_ff[0];
      endcase
      bitv = V_W'(1) << {cnt_ff, 1'b0};
      tsum = r_ff + bitv;
      num  = REM_W'({mag_sel[MAG_NB-1:0], {DIV_SHIFT{1'b0}}}) + REM_W'(r_ff[ROOT_W-1:0]);
      dk   = REM_W'({r_ff[ROOT_W-1:0], 1'b0}) << cnt_ff[3:0];
   end

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      sq_in    = sq_ff;
      len_in   = len_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      out_in   = out_ff;
      degen_in = degen_ff;
      done_in  = 1'b0;
      qf       = q_ff;
      case (state_ff)
         N_IDLE: begin
            if (req.start) begin
               neg_in[0] = req.sx[SUM_W-1];
               neg_in[1] = req.sy[SUM_W-1];
               neg_in[2] = req.sz[SUM_W-1];
               mag_in[0] = req.sx[SUM_W-1] ? (~req.sx + 1'b1) : req.sx;
               mag_in[1] = req.sy[SUM_W-1] ? (~req.sy + 1'b1) : req.sy;
               mag_in[2] = req.sz[SUM_W-1] ? (~req.sz + 1'b1) : req.sz;
               degen_in  = 1'b0;
               state_in  = N_SHIFT;
            end
         end
         N_SHIFT: begin
            // one bit per cycle until the largest magnitude is in [2^29, 2^30)
            if (mx == '0) begin
               for (int i = 0; i < 3; i++) out_in[i] = '0;
               degen_in = 1'b1;
               done_in  = 1'b1;
               state_in = N_IDLE;
            end else if (mx[MAG_W-1:MAG_NB] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!mx[MAG_NB-1]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               cnt_in   = 5'd0;
               len_in   = '0;
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            sq_in = SQ_W'(mag_sel[MAG_NB-1:0]) * SQ_W'(mag_sel[MAG_NB-1:0]);
            if (cnt_ff != 5'd0) begin
               len_in = len_ff + LEN_W'(sq_ff);
            end
            if (cnt_ff == 5'd3) begin
               v_in     = V_W'(len_ff + LEN_W'(sq_ff));
               r_in     = '0;
               cnt_in   = 5'd31;
               state_in = N_SQRT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         N_SQRT: begin
            if (v_ff >= tsum) begin
               v_in = v_ff - tsum;
               r_in = (r_ff >> 1) + bitv;
            end else begin
               r_in = r_ff >> 1;
            end
            if (cnt_ff == 5'd0) begin
               comp_in  = 2'd0;
               state_in = N_LOAD;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         N_LOAD: begin
            rem_in   = num;
            q_in     = '0;
            cnt_in   = 5'd15;
            state_in = N_DIV;
         end
         N_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_ff >= dk) begin
               rem_in = rem_ff - dk;
               qf     = q_ff | (Q_W'(1) << cnt_ff[3:0]);
            end
            q_in = qf;
            if (cnt_ff == 5'd0) begin
               out_in[comp_ff] = neg_ff[comp_ff] ? (~qf + 1'b1) : qf;
               if (comp_ff == 2'd2) begin
                  done_in  = 1'b1;
                  state_in = N_IDLE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = N_LOAD;
               end
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.done  = done_ff;
      rsp.degen = degen_ff;
      rsp.nx    = out_ff[0];
      rsp.ny    = out_ff[1];
      rsp.nz    = out_ff[2];
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      cnt_ff   <= cnt_in;
      comp_ff  <= comp_in;
      sq_ff    <= sq_in;
      len_ff   <= len_in;
      v_ff     <= v_in;
      r_ff     <= r_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      out_ff   <= out_in;
      degen_ff <= degen_in;
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/vna_core.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator back end
// Position and normal stores, the triangle sequencer and the face product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vna_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire vna_pkg::cmd_type   cmd,
   output logic                    cmd_pop,
   output logic                    res_valid,
   output vna_pkg::res_type        res,
   input  wire logic               res_ready,
   output logic                    init_busy
);
   import vna_pkg::*;

   localparam int NE_W = 1 + 3 * NRM_W;

   typedef enum logic [13:0] {
      C_INIT  = 14'b00000000000001,
      C_IDLE  = 14'b00000000000010,
      C_CLEAR = 14'b00000000000100,
      C_PA    = 14'b00000000001000,
      C_PB    = 14'b00000000010000,
      C_PC    = 14'b00000000100000,
      C_PD    = 14'b00000001000000,
      C_CROSS = 14'b00000010000000,
      C_NRD   = 14'b00000100000000,
      C_NLD   = 14'b00001000000000,
      C_NWT   = 14'b00010000000000,
      C_READ  = 14'b00100000000000,
      C_RDAT  = 14'b01000000000000,
      C_RESP  = 14'b10000000000000
   } core_state_type;

   core_state_type           state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   res_type                  res_ff, res_in;
   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic [1:0]               corner_ff, corner_in;
   logic [2:0]               step_ff, step_in;
   logic                     degen_ff, degen_in;
   logic signed [POS_W-1:0]  pa_ff [3], pa_in [3];
   logic signed [POS_W-1:0]  pb_ff [3], pb_in [3];
   logic signed [DIF_W-1:0]  u_ff [3], u_in [3];
   logic signed [DIF_W-1:0]  v_ff [3], v_in [3];
   logic signed [FACE_W-1:0] face_ff [3], face_in [3];
   logic signed [PRD_W-1:0]  prod_ff, prod_in;
   logic signed [DIF_W-1:0]  mul_a, mul_b;
   logic signed [POS_W-1:0]  prd [3];
   logic signed [NRM_W-1:0]  stored [3];
   logic [IDX_W-1:0]         cur_idx;

   logic                     pos_we;
   logic [IDX_W-1:0]         pos_raddr;
   logic [3*POS_W-1:0]       pos_rdata_ff;
   logic [3*POS_W-1:0]       pos_mem [MAX_VERTICES];
   logic                     nrm_we;
   logic [IDX_W-1:0]         nrm_waddr, nrm_raddr;
   logic [NE_W-1:0]          nrm_wdata;
   logic [NE_W-1:0]          nrm_rdata_ff;
   logic [NE_W-1:0]          nrm_mem [MAX_VERTICES];   // top bit: written
   nrm_req_type              nreq;
   nrm_rsp_type              nrsp;

   vna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rsp   (nrsp)
   );

   always_comb begin
      prd[0]    = $signed(pos_rdata_ff[3*POS_W-1:2*POS_W]);
      prd[1]    = $signed(pos_rdata_ff[2*POS_W-1:POS_W]);
      prd[2]    = $signed(pos_rdata_ff[POS_W-1:0]);
      stored[0] = $signed(nrm_rdata_ff[3*NRM_W-1:2*NRM_W]);
      stored[1] = $signed(nrm_rdata_ff[2*NRM_W-1:NRM_W]);
      stored[2] = $signed(nrm_rdata_ff[NRM_W-1:0]);
      case (corner_ff)
         2'd0:    cur_idx = cmd_ff.a;
         2'd1:    cur_idx = cmd_ff.b;
         default: cur_idx = cmd_ff.c;
      endcase
      case (step_ff)
         3'd0:    begin mul_a = u_ff[1]; mul_b = v_ff[2]; end
         3'd1:    begin mul_a = u_ff[2]; mul_b = v_ff[1]; end
         3'd2:    begin mul_a = u_ff[2]; mul_b = v_ff[0]; end
         3'd3:    begin mul_a = u_ff[0]; mul_b = v_ff[2]; end
         3'd4:    begin mul_a = u_ff[0]; mul_b = v_ff[1]; end
         default: begin mul_a = u_ff[1]; mul_b = v_ff[0]; end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      res_in    = res_ff;
      clr_in    = clr_ff;
      corner_in = corner_ff;
      step_in   = step_ff;
      degen_in  = degen_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      face_in   = face_ff;
      cmd_pop   = 1'b0;
      res_valid = 1'b0;
      pos_we    = 1'b0;
      pos_raddr = cmd_ff.a;
      nrm_we    = 1'b0;
      nrm_waddr = cur_idx;
      nrm_wdata = '0;
      nrm_raddr = cur_idx;
      nreq      = '0;
      case (state_ff)
         C_INIT, C_CLEAR: begin
            // clearing sweep: one entry per cycle through the normal store
            nrm_we    = 1'b1;
            nrm_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(MAX_VERTICES - 1)) begin
               state_in = (state_ff == C_INIT) ? C_IDLE : C_RESP;
            end
         end
         C_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd;
               res_in        = '0;
               res_in.status = cmd.bad ? STAT_RANGE : STAT_OK;
               clr_in        = '0;
               degen_in      = 1'b0;
               if (cmd.bad) begin
                  state_in = C_RESP;
               end else begin
                  case (cmd.kind)
                     REQ_WRITE_POS: begin
                        pos_we   = 1'b1;
                        state_in = C_RESP;
                     end
                     REQ_CLEAR:    state_in = C_CLEAR;
                     REQ_TRIANGLE: state_in = C_PA;
                     default:      state_in = C_READ;
                  endcase
               end
            end
         end
         C_PA: begin
            pos_raddr = cmd_ff.a;
            state_in  = C_PB;
         end
         C_PB: begin
            pos_raddr = cmd_ff.b;
            pa_in     = prd;
            state_in  = C_PC;
         end
         C_PC: begin
            pos_raddr = cmd_ff.c;
            pb_in     = prd;
            state_in  = C_PD;
         end
         C_PD: begin
            for (int i = 0; i < 3; i++) begin
               u_in[i]    = DIF_W'(pb_ff[i]) - DIF_W'(pa_ff[i]);
               v_in[i]    = DIF_W'(prd[i]) - DIF_W'(pa_ff[i]);
               face_in[i] = '0;
            end
            step_in  = 3'd0;
            state_in = C_CROSS;
         end
         C_CROSS: begin
            // product of step n is folded in at step n+1
            case (step_ff)
               3'd1:    face_in[0] = face_ff[0] + FACE_W'(prod_ff);
               3'd2:    face_in[0] = face_ff[0] - FACE_W'(prod_ff);
               3'd3:    face_in[1] = face_ff[1] + FACE_W'(prod_ff);
               3'd4:    face_in[1] = face_ff[1] - FACE_W'(prod_ff);
               3'd5:    face_in[2] = face_ff[2] + FACE_W'(prod_ff);
               3'd6:    face_in[2] = face_ff[2] - FACE_W'(prod_ff);
               default: face_in    = face_ff;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               corner_in = 2'd0;
               state_in  = C_NRD;
            end
         end
         C_NRD: begin
            state_in = C_NLD;
         end
         C_NLD: begin
            nreq.start = 1'b1;
            if (nrm_rdata_ff[NE_W-1]) begin
               nreq.sx = SUM_W'(face_ff[0]) + (SUM_W'(stored[0]) <<< 2);
               nreq.sy = SUM_W'(face_ff[1]) + (SUM_W'(stored[1]) <<< 2);
               nreq.sz = SUM_W'(face_ff[2]) + (SUM_W'(stored[2]) <<< 2);
            end else begin
               nreq.sx = SUM_W'(face_ff[0]);
               nreq.sy = SUM_W'(face_ff[1]);
               nreq.sz = SUM_W'(face_ff[2]);
            end
            state_in = C_NWT;
         end
         C_NWT: begin
            if (nrsp.done) begin
               nrm_we    = 1'b1;
               nrm_wdata = {1'b1, nrsp.nx, nrsp.ny, nrsp.nz};
               degen_in  = degen_ff | nrsp.degen;
               if (corner_ff == 2'd2) begin
                  res_in.status = (degen_ff | nrsp.degen) ? STAT_DEGEN : STAT_OK;
                  state_in      = C_RESP;
               end else begin
                  corner_in = corner_ff + 2'd1;
                  state_in  = C_NRD;
               end
            end
         end
         C_READ: begin
            nrm_raddr = cmd_ff.a;
            state_in  = C_RDAT;
         end
         C_RDAT: begin
            if (nrm_rdata_ff[NE_W-1]) begin
               res_in.nx = stored[0];
               res_in.ny = stored[1];
               res_in.nz = stored[2];
            end
            state_in = C_RESP;
         end
         C_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   assign res       = res_ff;
   assign init_busy = (state_ff == C_INIT);

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[cmd.a] <= {cmd.px, cmd.py, cmd.pz};
      end
      pos_rdata_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (nrm_we) begin
         nrm_mem[nrm_waddr] <= nrm_wdata;
      end
      nrm_rdata_ff <= nrm_mem[nrm_raddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      res_ff   <= res_in;
      degen_ff <= degen_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      face_ff  <= face_in;
      prod_ff  <= prod_in;
      if (reset) begin
         state_ff  <= C_INIT;
         clr_ff    <= '0;
         corner_ff <= 2'd0;
         step_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         corner_ff <= corner_in;
         step_ff   <= step_in;
      end
   end

endmodule
`default_nettype wire
